@@ design/rgp_pkg.sv @@
// ----------------------------------------------------------------------------
// rgp_pkg: shared types and constants of the rectangle grid pattern generator
// Register map, reset values, setup sequencer codes and the channel packer.
// ----------------------------------------------------------------------------
package rgp_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 11;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COLOR_W    = 32;

  // Color written on the bottom line when the height does not split evenly
  localparam logic [7:0] BOTTOM_COLOR = 8'hFF;

  // Register reset values
  localparam logic        RST_INDEXED_MODE      = 1'b1;
  localparam logic [7:0]  RST_RECT_COUNT        = 8'd1;
  localparam logic [31:0] RST_FIRST_COLOR       = 32'd0;
  localparam logic [7:0]  RST_COLOR_STEP        = 8'd1;
  localparam logic [10:0] RST_H_RESOLUTION      = 11'd1024;
  localparam logic [10:0] RST_V_RESOLUTION      = 11'd768;
  localparam logic [11:0] RST_CHANNEL_SIZES     = 12'd2184;
  localparam logic [14:0] RST_CHANNEL_POSITIONS = 15'd4264;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INDEXED_MODE      = 3'd0,
    REG_RECT_COUNT        = 3'd1,
    REG_FIRST_COLOR       = 3'd2,
    REG_COLOR_STEP        = 3'd3,
    REG_H_RESOLUTION      = 3'd4,
    REG_V_RESOLUTION      = 3'd5,
    REG_CHANNEL_SIZES     = 3'd6,
    REG_CHANNEL_POSITIONS = 3'd7
  } cfg_reg_e;

  // Geometry setup sequencer
  typedef enum logic [1:0] {
    SU_IDLE,
    SU_ISSUE,
    SU_WAIT
  } setup_state_e;

  // Division performed by the setup sequencer
  typedef enum logic [1:0] {
    OP_RECT_W,    // h_resolution / N
    OP_RECT_H,    // v_resolution / N, remainder kept
    OP_RECIP_W,   // reciprocal of rectangle width
    OP_RECIP_H    // reciprocal of rectangle height
  } div_op_e;

  // Pattern registers used by the color stages
  typedef struct packed {
    logic        indexed_mode;
    logic [7:0]  rect_count;
    logic [31:0] first_color;
    logic [7:0]  color_step;
    logic [11:0] channel_sizes;
    logic [14:0] channel_positions;
  } pattern_cfg_t;

  // Step one color channel of first_color and place it at its position
  function automatic logic [COLOR_W-1:0] make_channel(
    input logic [COLOR_W-1:0] first,
    input logic [3:0]         size,
    input logic [4:0]         pos,
    input logic [16:0]        delta
  );
    logic [15:0] mask;
    logic [15:0] start;
    logic [15:0] value;
    mask  = 16'((17'd1 << size) - 17'd1);
    start = 16'(first >> pos) & mask;
    value = (start + delta[15:0]) & mask;
    return COLOR_W'(value) << pos;
  endfunction

endpackage

@@ design/rgp_div.sv @@
// ----------------------------------------------------------------------------
// rgp_div: iterative restoring divider
// One quotient bit per cycle; a start request restarts it at any time.
// ----------------------------------------------------------------------------
module rgp_div #(
  parameter int DW = 22,  // dividend and quotient width
  parameter int VW = 11   // divisor and remainder width
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int CntW = $clog2(DW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [DW-1:0]   quot_q, quot_d;
  logic [VW-1:0]   rem_q, rem_d;
  logic [VW-1:0]   dvs_q;
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            ge;

  // Trial subtraction for the next quotient bit
  assign trial = {rem_q, quot_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d  = CntW'(DW);
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      quot_d = {quot_q[DW-2:0], ge};
      rem_d  = ge ? diff[VW-1:0] : trial[VW-1:0];
      done_d = (cnt_q == CntW'(1));
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ design/rectangle_grid_pattern_pixel.sv @@
// ----------------------------------------------------------------------------
// rectangle_grid_pattern_pixel: grid of rectangles test pattern, per pixel
// Maps a pixel coordinate to a write flag and a color for an N by N grid.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel request: pixel_x in the low COORD_BITS of
//   tdata, pixel_y above it. m_axis returns one result per request, in
//   order: pixel_color on tdata, write_enable on tuser (color is zero when
//   the pixel is not written).
//   Registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i while
//   no request is in flight. Each write, and reset, starts a geometry setup
//   that runs four divisions on a shared bit-serial divider: rectangle width
//   and height, then their reciprocals; s_axis_tready stays low meanwhile.
//   Afterwards one request is taken every cycle while the receiver keeps up;
//   results pass through five register stages to m_axis_tvalid: reciprocal
//   multiply, back-multiply, quotient correction, index products, color.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it fill their empty slots before s_axis_tready drops, so
//   nothing is lost or repeated. Reset empties the pipeline and restores the
//   register defaults.
// ----------------------------------------------------------------------------
module rectangle_grid_pattern_pixel #(
  parameter int  COORD_BITS = rgp_pkg::COORD_BITS_DEF,
  localparam int InDataW    = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Pixel requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [InDataW-1:0]            s_axis_tdata,   // pixel_x, pixel_y, zero pad
  // Results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rgp_pkg::COLOR_W-1:0]   m_axis_tdata,   // pixel_color
  output logic                          m_axis_tuser,   // write_enable
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [rgp_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [rgp_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int CB = COORD_BITS;
  localparam int DW = 2 * COORD_BITS;     // reciprocal scale
  localparam int PW = COORD_BITS + DW;    // coordinate times reciprocal

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  rgp_pkg::pattern_cfg_t pat_q;
  logic [10:0]           h_res_q;
  logic [10:0]           v_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q.indexed_mode      <= rgp_pkg::RST_INDEXED_MODE;
      pat_q.rect_count        <= rgp_pkg::RST_RECT_COUNT;
      pat_q.first_color       <= rgp_pkg::RST_FIRST_COLOR;
      pat_q.color_step        <= rgp_pkg::RST_COLOR_STEP;
      pat_q.channel_sizes     <= rgp_pkg::RST_CHANNEL_SIZES;
      pat_q.channel_positions <= rgp_pkg::RST_CHANNEL_POSITIONS;
      h_res_q                 <= rgp_pkg::RST_H_RESOLUTION;
      v_res_q                 <= rgp_pkg::RST_V_RESOLUTION;
    end else if (cfg_we_i) begin
      unique case (rgp_pkg::cfg_reg_e'(cfg_addr_i))
        rgp_pkg::REG_INDEXED_MODE:      pat_q.indexed_mode      <= cfg_wdata_i[0];
        rgp_pkg::REG_RECT_COUNT:        pat_q.rect_count        <= cfg_wdata_i[7:0];
        rgp_pkg::REG_FIRST_COLOR:       pat_q.first_color       <= cfg_wdata_i;
        rgp_pkg::REG_COLOR_STEP:        pat_q.color_step        <= cfg_wdata_i[7:0];
        rgp_pkg::REG_H_RESOLUTION:      h_res_q                 <= cfg_wdata_i[10:0];
        rgp_pkg::REG_V_RESOLUTION:      v_res_q                 <= cfg_wdata_i[10:0];
        rgp_pkg::REG_CHANNEL_SIZES:     pat_q.channel_sizes     <= cfg_wdata_i[11:0];
        rgp_pkg::REG_CHANNEL_POSITIONS: pat_q.channel_positions <= cfg_wdata_i[14:0];
      endcase
    end
  end

  // Resolutions seen at coordinate width, zero count taken as one
  logic [CB-1:0] hres_c;
  logic [CB-1:0] vres_c;
  logic [7:0]    n_c;

  assign hres_c = CB'(h_res_q);
  assign vres_c = CB'(v_res_q);
  assign n_c    = (pat_q.rect_count == 8'd0) ? 8'd1 : pat_q.rect_count;

  // --------------------------------------------------------------------------
  // Geometry setup: rectangle size, bottom remainder and reciprocals
  // --------------------------------------------------------------------------
  rgp_pkg::setup_state_e su_state_q, su_state_d;
  rgp_pkg::div_op_e      op_q, op_d;
  logic                  div_start;
  logic [DW-1:0]         div_dividend;
  logic [CB-1:0]         div_divisor;
  logic                  div_done;
  logic [DW-1:0]         div_quot;
  logic [CB-1:0]         div_rem;
  logic                  setup_busy;

  logic [CB-1:0] rect_w_q;
  logic [CB-1:0] rect_h_q;
  logic [CB-1:0] v_rem_q;
  logic [DW-1:0] recip_w_q;
  logic [DW-1:0] recip_h_q;

  // Next state of the sequencer
  always_comb begin
    su_state_d = su_state_q;
    op_d       = op_q;
    div_start  = 1'b0;
    unique case (su_state_q)
      rgp_pkg::SU_IDLE: ;
      rgp_pkg::SU_ISSUE: begin
        div_start  = 1'b1;
        su_state_d = rgp_pkg::SU_WAIT;
      end
      rgp_pkg::SU_WAIT: begin
        if (div_done) begin
          if (op_q == rgp_pkg::OP_RECIP_H) begin
            su_state_d = rgp_pkg::SU_IDLE;
          end else begin
            op_d       = rgp_pkg::div_op_e'(op_q + 2'd1);
            su_state_d = rgp_pkg::SU_ISSUE;
          end
        end
      end
      default: su_state_d = rgp_pkg::SU_ISSUE;
    endcase
    // Any register write reruns the whole setup
    if (cfg_we_i) begin
      su_state_d = rgp_pkg::SU_ISSUE;
      op_d       = rgp_pkg::OP_RECT_W;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      su_state_q <= rgp_pkg::SU_ISSUE;
      op_q       <= rgp_pkg::OP_RECT_W;
    end else begin
      su_state_q <= su_state_d;
      op_q       <= op_d;
    end
  end

  assign setup_busy = (su_state_q != rgp_pkg::SU_IDLE);

  // Operands for the current division
  always_comb begin
    unique case (op_q)
      rgp_pkg::OP_RECT_W: begin
        div_dividend = DW'(hres_c);
        div_divisor  = CB'(n_c);
      end
      rgp_pkg::OP_RECT_H: begin
        div_dividend = DW'(vres_c);
        div_divisor  = CB'(n_c);
      end
      rgp_pkg::OP_RECIP_W: begin
        div_dividend = '1;
        div_divisor  = rect_w_q;
      end
      rgp_pkg::OP_RECIP_H: begin
        div_dividend = '1;
        div_divisor  = rect_h_q;
      end
      default: begin
        div_dividend = '1;
        div_divisor  = rect_h_q;
      end
    endcase
  end

  rgp_div #(
    .DW (DW),
    .VW (CB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Capture division results
  always_ff @(posedge clk_i) begin
    if (div_done && su_state_q == rgp_pkg::SU_WAIT) begin
      unique case (op_q)
        rgp_pkg::OP_RECT_W:  rect_w_q  <= div_quot[CB-1:0];
        rgp_pkg::OP_RECT_H: begin
          rect_h_q <= div_quot[CB-1:0];
          v_rem_q  <= div_rem;
        end
        rgp_pkg::OP_RECIP_W: recip_w_q <= div_quot;
        rgp_pkg::OP_RECIP_H: recip_h_q <= div_quot;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pixel pipeline with per-stage valids; empty stages keep filling on stall
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, eno;
  logic in_acc;

  assign eno    = !vo_q || m_axis_tready;
  assign en4    = !v4_q || eno;
  assign en3    = !v3_q || en4;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign s_axis_tready = en1 && !setup_busy;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_acc;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (eno) vo_q <= v4_q;
    end
  end

  // Stage 1: bounds checks and reciprocal products
  logic [CB-1:0] px_in, py_in;
  logic [CB-1:0] x1_q, y1_q;
  logic [PW-1:0] prx1_q, pry1_q;
  logic          in1_q, bot1_q;

  assign px_in = s_axis_tdata[CB-1:0];
  assign py_in = s_axis_tdata[2*CB-1:CB];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q   <= px_in;
      y1_q   <= py_in;
      prx1_q <= PW'(px_in) * PW'(recip_w_q);
      pry1_q <= PW'(py_in) * PW'(recip_h_q);
      in1_q  <= (px_in < hres_c) && (py_in < vres_c);
      bot1_q <= (py_in == vres_c - 1'b1) && (px_in < hres_c);
    end
  end

  // Stage 2: quotient estimates multiplied back
  logic [CB-1:0] qx_c, qy_c;
  logic [CB-1:0] x2_q, y2_q, qx2_q, qy2_q, bx2_q, by2_q;
  logic          in2_q, bot2_q;

  assign qx_c = prx1_q[PW-1:DW];
  assign qy_c = pry1_q[PW-1:DW];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      qx2_q  <= qx_c;
      qy2_q  <= qy_c;
      bx2_q  <= qx_c * rect_w_q;
      by2_q  <= qy_c * rect_h_q;
      in2_q  <= in1_q;
      bot2_q <= bot1_q;
    end
  end

  // Stage 3: correct the estimates, decide the write
  logic [CB-1:0] rx_c, ry_c, col_c, row_c;
  logic          we_c;
  logic [7:0]    col3_q, row3_q;
  logic          we3_q;

  assign rx_c  = x2_q - bx2_q;
  assign ry_c  = y2_q - by2_q;
  assign col_c = qx2_q + {{(CB-1){1'b0}}, (rx_c >= rect_w_q)};
  assign row_c = qy2_q + {{(CB-1){1'b0}}, (ry_c >= rect_h_q)};

  always_comb begin
    if (v_rem_q != '0) begin
      we_c = bot2_q;
    end else begin
      we_c = (rect_w_q != '0) && (rect_h_q != '0) && in2_q
             && (col_c < CB'(n_c)) && (row_c < CB'(n_c));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      col3_q <= col_c[7:0];
      row3_q <= row_c[7:0];
      we3_q  <= we_c;
    end
  end

  // Stage 4: rectangle index and channel steps
  logic [7:0]  idx4_q;
  logic [16:0] dr4_q, dg4_q, db4_q;
  logic        we4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      idx4_q <= row3_q * n_c + col3_q;
      dr4_q  <= 17'(col3_q) * 17'(pat_q.color_step);
      dg4_q  <= 17'(row3_q) * 17'(pat_q.color_step);
      db4_q  <= (17'(col3_q) + 17'(row3_q)) * 17'(pat_q.color_step);
      we4_q  <= we3_q;
    end
  end

  // Stage 5: final color into the output register
  logic [7:0]                  idx_color;
  logic [rgp_pkg::COLOR_W-1:0] rgb_color;
  logic [rgp_pkg::COLOR_W-1:0] color_c;
  logic [rgp_pkg::COLOR_W-1:0] color_q;
  logic                        we_q;

  assign idx_color = pat_q.first_color[7:0] + 8'(idx4_q * pat_q.color_step);
  assign rgb_color =
      rgp_pkg::make_channel(pat_q.first_color, pat_q.channel_sizes[3:0],
                            pat_q.channel_positions[4:0], dr4_q)
    | rgp_pkg::make_channel(pat_q.first_color, pat_q.channel_sizes[7:4],
                            pat_q.channel_positions[9:5], dg4_q)
    | rgp_pkg::make_channel(pat_q.first_color, pat_q.channel_sizes[11:8],
                            pat_q.channel_positions[14:10], db4_q);

  always_comb begin
    if (!we4_q) begin
      color_c = '0;
    end else if (v_rem_q != '0) begin
      color_c = rgp_pkg::COLOR_W'(rgp_pkg::BOTTOM_COLOR);
    end else if (pat_q.indexed_mode) begin
      color_c = rgp_pkg::COLOR_W'(idx_color);
    end else begin
      color_c = rgb_color;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno) begin
      color_q <= color_c;
      we_q    <= we4_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = color_q;
  assign m_axis_tuser  = we_q;

endmodule

@@ design/rgp_checker.sv @@
// ----------------------------------------------------------------------------
// rgp_checker: port-level checks for rectangle_grid_pattern_pixel
// Watches the stream ports and the configuration port of the top level.
// ----------------------------------------------------------------------------
module rgp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rgp_pkg::COLOR_W-1:0]   m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          cfg_we_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Unwritten pixels carry no color
  a_color_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("color on an unwritten pixel");

  // A register write starts geometry setup, which blocks requests
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("request taken during setup");

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid && !s_axis_tready)
    else $error("activity right after reset");

endmodule

bind rectangle_grid_pattern_pixel rgp_checker u_rgp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_we_i      (cfg_we_i)
);
